// ===== sv/pidpi_pkg.sv =====
// Shared types and constants for the positional/incremental PID controller.
// Used by pidpi_core and by pid_position_or_incremental_controller_top.
package pidpi_pkg;

  // Fixed widths of the configuration fields and of the drive output.
  localparam int GAIN_W  = 24;
  localparam int LIMIT_W = 15;
  localparam int DRIVE_W = 16;
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_INDEX_W = 3;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  // Register indexes on the configuration port.
  localparam cfg_index_t CFG_MODE_INCREMENTAL = 3'd0;
  localparam cfg_index_t CFG_GAIN_P           = 3'd1;
  localparam cfg_index_t CFG_GAIN_I           = 3'd2;
  localparam cfg_index_t CFG_GAIN_D           = 3'd3;
  localparam cfg_index_t CFG_INTEGRAL_LIMIT   = 3'd4;
  localparam cfg_index_t CFG_OUTPUT_LIMIT     = 3'd5;

  // Reset value of both symmetric limits.
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd16384;

  // Configuration registers as seen by the datapath.
  typedef struct packed {
    logic               mode_incremental;
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic [LIMIT_W-1:0] integral_limit;
    logic [LIMIT_W-1:0] output_limit;
  } pidpi_cfg_t;

endpackage

// ===== sv/pid_position_or_incremental_controller_top.sv =====
// Top level of the positional/incremental PID controller: handshakes, state, config.
// Depends on pidpi_pkg and instantiates pidpi_core.

// One beat in (measured, setpoint) gives one beat out (drive). The block takes a
// beat in every cycle while the output side is not stalled: a beat lands in the input
// register, and from there the whole controller step (error, three gain products,
// integral and output clamps, truncation toward zero) runs in one pass into the
// output register, which raises out_valid. The error history and the two
// accumulators are written at that same edge, and this feedback loop still allows
// one beat per cycle when the output side is not stalled. Configuration
// writes are taken in any cycle and should only be made while no beat is in flight.
module pid_position_or_incremental_controller_top #(
  parameter int SAMPLE_BITS    = 24,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [SAMPLE_BITS-1:0]         in_measured,
  input  logic signed [SAMPLE_BITS-1:0]         in_setpoint,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [pidpi_pkg::DRIVE_W-1:0]  out_drive,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  pidpi_pkg::cfg_index_t                 cfg_index,
  input  logic [pidpi_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int ACC_W = pidpi_pkg::LIMIT_W + 1 + GAIN_FRAC_BITS;

  pidpi_pkg::pidpi_cfg_t cfg_r;

  logic                           in_valid_r;
  logic signed [SAMPLE_BITS-1:0]  meas_r, setp_r;
  logic signed [SAMPLE_BITS:0]    error_last_r, error_before_last_r, error_nxt;
  logic signed [ACC_W-1:0]        integral_acc_r, output_acc_r;
  logic signed [ACC_W-1:0]        integral_acc_nxt, output_acc_nxt;
  logic signed [pidpi_pkg::DRIVE_W-1:0] drive_nxt;
  logic                           out_valid_r;
  logic signed [pidpi_pkg::DRIVE_W-1:0] out_drive_r;
  logic                           advance;

  // The input register moves on when the output register is free or being drained.
  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !in_valid_r || advance;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_drive = out_drive_r;

  // Configuration registers, masked to each field's width.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode_incremental <= 1'b0;
      cfg_r.gain_p           <= '0;
      cfg_r.gain_i           <= '0;
      cfg_r.gain_d           <= '0;
      cfg_r.integral_limit   <= pidpi_pkg::LIMIT_RESET;
      cfg_r.output_limit     <= pidpi_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pidpi_pkg::CFG_MODE_INCREMENTAL: cfg_r.mode_incremental <= cfg_data[0];
        pidpi_pkg::CFG_GAIN_P:           cfg_r.gain_p <= cfg_data[pidpi_pkg::GAIN_W-1:0];
        pidpi_pkg::CFG_GAIN_I:           cfg_r.gain_i <= cfg_data[pidpi_pkg::GAIN_W-1:0];
        pidpi_pkg::CFG_GAIN_D:           cfg_r.gain_d <= cfg_data[pidpi_pkg::GAIN_W-1:0];
        pidpi_pkg::CFG_INTEGRAL_LIMIT: begin
          cfg_r.integral_limit <= cfg_data[pidpi_pkg::LIMIT_W-1:0];
        end
        pidpi_pkg::CFG_OUTPUT_LIMIT: begin
          cfg_r.output_limit <= cfg_data[pidpi_pkg::LIMIT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Input register: valid flag and payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      meas_r <= in_measured;
      setp_r <= in_setpoint;
    end
  end

  pidpi_core #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
    .ACC_W          (ACC_W)
  ) u_core (
    .cfg               (cfg_r),
    .measured          (meas_r),
    .setpoint          (setp_r),
    .error_last        (error_last_r),
    .error_before_last (error_before_last_r),
    .integral_acc      (integral_acc_r),
    .output_acc        (output_acc_r),
    .error_nxt         (error_nxt),
    .integral_acc_nxt  (integral_acc_nxt),
    .output_acc_nxt    (output_acc_nxt),
    .drive             (drive_nxt)
  );

  // Controller state moves on once per beat, as the beat enters the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_last_r        <= '0;
      error_before_last_r <= '0;
      integral_acc_r      <= '0;
      output_acc_r        <= '0;
    end else if (in_valid_r && advance) begin
      error_last_r        <= error_nxt;
      error_before_last_r <= error_last_r;
      integral_acc_r      <= integral_acc_nxt;
      output_acc_r        <= output_acc_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r && advance) begin
      out_drive_r <= drive_nxt;
    end
  end

endmodule

// ===== sv/pidpi_core.sv =====
// Combinational PID datapath: error, three gain products, clamps and truncation.
// Depends on pidpi_pkg for the configuration struct and field widths.
module pidpi_core #(
  parameter int SAMPLE_BITS    = 24,
  parameter int GAIN_FRAC_BITS = 16,
  parameter int ACC_W          = pidpi_pkg::LIMIT_W + 1 + GAIN_FRAC_BITS
) (
  input  pidpi_pkg::pidpi_cfg_t                cfg,
  input  logic signed [SAMPLE_BITS-1:0]        measured,
  input  logic signed [SAMPLE_BITS-1:0]        setpoint,
  input  logic signed [SAMPLE_BITS:0]          error_last,
  input  logic signed [SAMPLE_BITS:0]          error_before_last,
  input  logic signed [ACC_W-1:0]              integral_acc,
  input  logic signed [ACC_W-1:0]              output_acc,
  output logic signed [SAMPLE_BITS:0]          error_nxt,
  output logic signed [ACC_W-1:0]              integral_acc_nxt,
  output logic signed [ACC_W-1:0]              output_acc_nxt,
  output logic signed [pidpi_pkg::DRIVE_W-1:0] drive
);

  // Error terms carry up to three extra bits for the second difference.
  localparam int EW     = SAMPLE_BITS + 3;
  localparam int PW     = pidpi_pkg::GAIN_W + 1 + EW;
  localparam int WIDEST = (PW > ACC_W) ? PW : ACC_W;
  localparam int SUM_W  = WIDEST + 3;
  localparam int LIM_W  = pidpi_pkg::LIMIT_W + GAIN_FRAC_BITS;

  logic signed [EW-1:0] e_x, e1_x, e2_x, d1, d2;
  logic signed [EW-1:0] op_p, op_d;
  logic signed [pidpi_pkg::GAIN_W:0] kp_s, ki_s, kd_s;
  logic signed [PW-1:0] prod_p, prod_i, prod_d;
  logic signed [SUM_W-1:0] prod_p_x, prod_i_x, prod_d_x;
  logic signed [SUM_W-1:0] iacc_x, oacc_x, isum, iclamp, base, osum, oclamp;
  logic signed [SUM_W-1:0] ilim, olim;
  logic neg_frac;

  // The new error and its first and second differences.
  assign error_nxt = $signed({setpoint[SAMPLE_BITS-1], setpoint})
                   - $signed({measured[SAMPLE_BITS-1], measured});
  assign e_x  = {{2{error_nxt[SAMPLE_BITS]}}, error_nxt};
  assign e1_x = {{2{error_last[SAMPLE_BITS]}}, error_last};
  assign e2_x = {{2{error_before_last[SAMPLE_BITS]}}, error_before_last};
  assign d1   = e_x - e1_x;
  assign d2   = e_x - e1_x - e1_x + e2_x;

  // Three shared multipliers; the mode picks the error term for P and D.
  assign kp_s = $signed({1'b0, cfg.gain_p});
  assign ki_s = $signed({1'b0, cfg.gain_i});
  assign kd_s = $signed({1'b0, cfg.gain_d});
  assign op_p = cfg.mode_incremental ? d1 : e_x;
  assign op_d = cfg.mode_incremental ? d2 : d1;
  assign prod_p = kp_s * op_p;
  assign prod_i = ki_s * e_x;
  assign prod_d = kd_s * op_d;
  assign prod_p_x = {{(SUM_W-PW){prod_p[PW-1]}}, prod_p};
  assign prod_i_x = {{(SUM_W-PW){prod_i[PW-1]}}, prod_i};
  assign prod_d_x = {{(SUM_W-PW){prod_d[PW-1]}}, prod_d};

  // Limits scaled to the fixed-point grid of the accumulators.
  assign ilim = $signed({{(SUM_W-LIM_W){1'b0}}, cfg.integral_limit, {GAIN_FRAC_BITS{1'b0}}});
  assign olim = $signed({{(SUM_W-LIM_W){1'b0}}, cfg.output_limit, {GAIN_FRAC_BITS{1'b0}}});

  assign iacc_x = {{(SUM_W-ACC_W){integral_acc[ACC_W-1]}}, integral_acc};
  assign oacc_x = {{(SUM_W-ACC_W){output_acc[ACC_W-1]}}, output_acc};

  // Integral path, used in positional mode only.
  always_comb begin
    isum = iacc_x + prod_i_x;
    if (isum > ilim) begin
      iclamp = ilim;
    end else if (isum < -ilim) begin
      iclamp = -ilim;
    end else begin
      iclamp = isum;
    end
  end

  // Output sum: positional adds the clamped integral, incremental adds to the old output.
  always_comb begin
    if (cfg.mode_incremental) begin
      base = oacc_x + prod_i_x;
    end else begin
      base = iclamp;
    end
    osum = base + prod_p_x + prod_d_x;
    if (osum > olim) begin
      oclamp = olim;
    end else if (osum < -olim) begin
      oclamp = -olim;
    end else begin
      oclamp = osum;
    end
  end

  assign integral_acc_nxt = cfg.mode_incremental ? integral_acc : iclamp[ACC_W-1:0];
  assign output_acc_nxt   = oclamp[ACC_W-1:0];

  // Truncate toward zero: a negative value with a fractional part moves up by one.
  assign neg_frac = output_acc_nxt[ACC_W-1] & (|output_acc_nxt[GAIN_FRAC_BITS-1:0]);
  assign drive = $signed(output_acc_nxt[ACC_W-1:GAIN_FRAC_BITS])
               + $signed({{(pidpi_pkg::DRIVE_W-1){1'b0}}, neg_frac});

endmodule
